// ===== hdl/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Operation and status codes, sequencer states, sizes and the result bundle
// passed from the core to the output stage.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  // request operation codes
  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_POP_FRONT  = 4'd4,
    OP_ERASE      = 4'd5,
    OP_FIND       = 4'd6,
    OP_MODIFY     = 4'd7,
    OP_READ       = 4'd8
  } op_t;

  // response status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_DRAIN,
    S_PUT,
    S_DN,
    S_DN_DRAIN,
    S_FIND,
    S_READ,
    S_FINISH
  } state_t;

  // finished result from the core
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [CNT_W-1:0]    found_position;
    logic [DATA_W-1:0]   read_value;
    logic [CNT_W-1:0]    entry_total;
  } result_t;

endpackage

// ===== hdl/sle_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_if: request and response channels of the sequential list engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sle_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface sle_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         found_position;
  logic signed [31:0] read_value;
  logic [6:0]         entry_total;

  modport source (output valid, output status, output found_position,
                  output read_value, output entry_total, input ready);
  modport sink   (input valid, input status, input found_position,
                  input read_value, input entry_total, output ready);
endinterface

// ===== hdl/sle_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_core: list storage and operation sequencer
// Holds the entries in a synchronous RAM and walks it one entry per cycle
// to shift entries for insert and erase, and to search for find.
// ----------------------------------------------------------------------------
module sle_core (
  input  logic                 clk,
  input  logic                 rst,
  sle_req_if.sink              req,
  output sle_pkg::result_t     res,
  input  logic                 res_ready
);

  // entry storage, one read and one write port, registered read
  logic [sle_pkg::DATA_W-1:0] mem [sle_pkg::CAPACITY];
  logic [sle_pkg::DATA_W-1:0] rdata;

  // sequencer registers
  sle_pkg::state_t            state;
  sle_pkg::state_t            state_next;
  logic [sle_pkg::CNT_W-1:0]  count;
  logic [sle_pkg::CNT_W-1:0]  ptr;
  logic [sle_pkg::IDX_W-1:0]  slot;
  logic [sle_pkg::DATA_W-1:0] key;
  logic                       rd_pend;
  logic [sle_pkg::IDX_W-1:0]  rd_q;
  sle_pkg::status_t           res_status;
  logic [sle_pkg::CNT_W-1:0]  res_found;
  logic [sle_pkg::DATA_W-1:0] res_read;

  // RAM controls
  logic                       rd_en;
  logic [sle_pkg::IDX_W-1:0]  rd_addr;
  logic                       wr_en;
  logic [sle_pkg::IDX_W-1:0]  wr_addr;
  logic [sle_pkg::DATA_W-1:0] wr_data;

  // request decode
  logic                       acc;
  logic                       full;
  logic                       pos_ok;
  logic                       ins_pos_ok;
  logic [sle_pkg::IDX_W-1:0]  pos_m1;
  logic [sle_pkg::IDX_W-1:0]  ins_slot;
  logic [sle_pkg::IDX_W-1:0]  del_slot;
  sle_pkg::status_t           dec_status;
  sle_pkg::state_t            dec_target;
  logic [sle_pkg::IDX_W-1:0]  dec_slot;
  logic [sle_pkg::CNT_W-1:0]  dec_ptr;
  logic                       dec_write;
  logic                       dec_read;
  logic                       dec_inc;
  logic                       dec_dec;

  logic                       find_issue;
  logic                       match;

  assign acc        = req.valid && req.ready;
  assign full       = (count == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
  assign pos_m1     = sle_pkg::IDX_W'(req.position - 7'd1);
  assign pos_ok     = (req.position != 7'd0) &&
                      ({1'b0, req.position} <= (sle_pkg::CNT_W+1)'(count));
  assign ins_pos_ok = (req.position != 7'd0) &&
                      ({1'b0, req.position} <= ((sle_pkg::CNT_W+1)'(count) + 1'b1));
  assign find_issue = (ptr < count);
  assign match      = rd_pend && (rdata == key);

  // slot for the growing operations
  always_comb begin
    case (req.operation)
      sle_pkg::OP_PUSH_BACK:  ins_slot = count[sle_pkg::IDX_W-1:0];
      sle_pkg::OP_PUSH_FRONT: ins_slot = '0;
      default:                ins_slot = pos_m1;
    endcase
  end

  // slot for the shrinking operations
  always_comb begin
    case (req.operation)
      sle_pkg::OP_POP_BACK:  del_slot = sle_pkg::IDX_W'(count - 1'b1);
      sle_pkg::OP_POP_FRONT: del_slot = '0;
      default:               del_slot = pos_m1;
    endcase
  end

  // decode of an incoming request
  always_comb begin
    dec_status = sle_pkg::ST_OK;
    dec_target = sle_pkg::S_FINISH;
    dec_slot   = '0;
    dec_ptr    = '0;
    dec_write  = 1'b0;
    dec_read   = 1'b0;
    dec_inc    = 1'b0;
    dec_dec    = 1'b0;
    case (req.operation)
      sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_INSERT: begin
        if (req.operation == sle_pkg::OP_INSERT && !ins_pos_ok) begin
          dec_status = sle_pkg::ST_BADPOS;
        end else if (full) begin
          dec_status = sle_pkg::ST_FULL;
        end else begin
          dec_slot = ins_slot;
          if ({1'b0, ins_slot} == count) begin
            // lands at the end: nothing to move
            dec_write = 1'b1;
            dec_inc   = 1'b1;
          end else begin
            dec_target = sle_pkg::S_UP;
            dec_ptr    = count - 1'b1;
          end
        end
      end
      sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT, sle_pkg::OP_ERASE: begin
        if (req.operation == sle_pkg::OP_ERASE && !pos_ok) begin
          dec_status = sle_pkg::ST_BADPOS;
        end else if (count == '0) begin
          dec_status = sle_pkg::ST_EMPTY;
        end else begin
          dec_slot = del_slot;
          if ({1'b0, del_slot} == (count - 1'b1)) begin
            // last entry goes: nothing to move
            dec_dec = 1'b1;
          end else begin
            dec_target = sle_pkg::S_DN;
            dec_ptr    = {1'b0, del_slot} + 1'b1;
          end
        end
      end
      sle_pkg::OP_FIND: begin
        if (count == '0) begin
          dec_status = sle_pkg::ST_NOTFOUND;
        end else begin
          dec_target = sle_pkg::S_FIND;
        end
      end
      sle_pkg::OP_MODIFY: begin
        if (!pos_ok) begin
          dec_status = sle_pkg::ST_BADPOS;
        end else begin
          dec_slot  = pos_m1;
          dec_write = 1'b1;
        end
      end
      sle_pkg::OP_READ: begin
        if (!pos_ok) begin
          dec_status = sle_pkg::ST_BADPOS;
        end else begin
          dec_read   = 1'b1;
          dec_target = sle_pkg::S_READ;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::S_IDLE:     if (acc) state_next = dec_target;
      sle_pkg::S_UP:       if (ptr[sle_pkg::IDX_W-1:0] == slot) state_next = sle_pkg::S_UP_DRAIN;
      sle_pkg::S_UP_DRAIN: state_next = sle_pkg::S_PUT;
      sle_pkg::S_PUT:      state_next = sle_pkg::S_FINISH;
      sle_pkg::S_DN:       if (ptr == (count - 1'b1)) state_next = sle_pkg::S_DN_DRAIN;
      sle_pkg::S_DN_DRAIN: state_next = sle_pkg::S_FINISH;
      sle_pkg::S_FIND:     if (match || !find_issue) state_next = sle_pkg::S_FINISH;
      sle_pkg::S_READ:     state_next = sle_pkg::S_FINISH;
      sle_pkg::S_FINISH:   if (res_ready) state_next = sle_pkg::S_IDLE;
      default:             state_next = sle_pkg::S_IDLE;
    endcase
  end

  // RAM port controls per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[sle_pkg::IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_q + 1'b1;
    wr_data = rdata;
    case (state)
      sle_pkg::S_IDLE: begin
        rd_en   = acc && dec_read;
        rd_addr = pos_m1;
        wr_en   = acc && dec_write;
        wr_addr = dec_slot;
        wr_data = req.value;
      end
      sle_pkg::S_UP: begin
        rd_en = 1'b1;
        wr_en = rd_pend;
      end
      sle_pkg::S_UP_DRAIN: wr_en = 1'b1;
      sle_pkg::S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = key;
      end
      sle_pkg::S_DN: begin
        rd_en   = 1'b1;
        wr_en   = rd_pend;
        wr_addr = rd_q - 1'b1;
      end
      sle_pkg::S_DN_DRAIN: begin
        wr_en   = 1'b1;
        wr_addr = rd_q - 1'b1;
      end
      sle_pkg::S_FIND: rd_en = find_issue;
      default: ;
    endcase
  end

  assign req.ready = (state == sle_pkg::S_IDLE);

  assign res.valid          = (state == sle_pkg::S_FINISH);
  assign res.status         = res_status;
  assign res.found_position = res_found;
  assign res.read_value     = res_read;
  assign res.entry_total    = count;

  // storage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sle_pkg::S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en && (state != sle_pkg::S_IDLE);
      case (state)
        sle_pkg::S_IDLE: begin
          if (acc && dec_inc) count <= count + 1'b1;
          if (acc && dec_dec) count <= count - 1'b1;
        end
        sle_pkg::S_PUT:      count <= count + 1'b1;
        sle_pkg::S_DN_DRAIN: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // walk pointer, request copy and result
  always_ff @(posedge clk) begin
    rd_q <= rd_addr;
    case (state)
      sle_pkg::S_IDLE: begin
        if (acc) begin
          ptr        <= dec_ptr;
          slot       <= dec_slot;
          key        <= req.value;
          res_status <= dec_status;
          res_found  <= '0;
          res_read   <= '0;
        end
      end
      sle_pkg::S_UP:   ptr <= ptr - 1'b1;
      sle_pkg::S_DN:   ptr <= ptr + 1'b1;
      sle_pkg::S_FIND: begin
        ptr <= ptr + 1'b1;
        if (match) begin
          res_status <= sle_pkg::ST_OK;
          res_found  <= {1'b0, rd_q} + 1'b1;
        end else if (!find_issue) begin
          res_status <= sle_pkg::ST_NOTFOUND;
        end
      end
      sle_pkg::S_READ: res_read <= rdata;
      default: ;
    endcase
  end

endmodule

// ===== hdl/sequential_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list of up to 64 signed words
// Push, pop, insert, erase, find, modify and read on a RAM-held list.
// ----------------------------------------------------------------------------
// The engine takes one request at a time and answers each with one response
// beat. The entries live in a 64-word RAM with a registered read port, so all
// work that moves or scans entries goes one entry per cycle through that
// port. Push_back, pop_back, modify, failed checks and unknown codes need no
// walk; read waits for its registered RAM read. When entries have to move,
// insert and push_front shift the entries behind the slot up, and erase and
// pop_front shift them down; an insert at the end or an erase of the last
// entry moves nothing. Find scans from the front until it matches or has
// passed every entry held. A new request is taken once the previous one has
// reached the response register, even if that beat is still waiting to be
// taken. No clearing is needed after reset.
// ----------------------------------------------------------------------------
module sequential_list_engine (
  input  logic      clk,
  input  logic      rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  sle_pkg::result_t res;
  logic             res_ready;

  sle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_ready (res_ready)
  );

  // response register: loads when empty or being drained
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      rsp.status         <= res.status;
      rsp.found_position <= res.found_position;
      rsp.read_value     <= res.read_value;
      rsp.entry_total    <= res.entry_total;
    end
  end

  // count never exceeds the capacity
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_total <= 7'(sle_pkg::CAPACITY)))
    else $error("entry total beyond capacity");

  // a failed request carries neither position nor data
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != sle_pkg::ST_OK) |->
      (rsp.found_position == 7'd0) && (rsp.read_value == 32'sd0))
    else $error("failed request returned position or data");

  // full is only reported on a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == sle_pkg::ST_FULL) |->
      (rsp.entry_total == 7'(sle_pkg::CAPACITY)))
    else $error("full reported below capacity");

  // empty is only reported on an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == sle_pkg::ST_EMPTY) |-> (rsp.entry_total == 7'd0))
    else $error("empty reported with entries held");

endmodule

// ===== bench/sequential_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_test: self-checking bench for the list engine
// Drives list requests over the request channel, keeps its own copy of the
// list to work out each response, and compares every response beat field by
// field in order. Directed edge cases come first, then random traffic that
// swings the list between empty and full under several idling patterns.
// ----------------------------------------------------------------------------
module sequential_list_engine_test;

  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          DRAIN_CYCLES    = 200;
  localparam int          PRINT_LIMIT     = 100;
  localparam logic [3:0]  OP_SPARE_FIRST  = 4'(sle_pkg::OP_READ) + 4'd1;
  localparam logic [3:0]  OP_SPARE_LAST   = 4'hF;
  localparam logic [6:0]  POS_TOP         = 7'h7F;

  // one expected response beat
  typedef struct {
    sle_pkg::status_t   status;
    logic [6:0]         found_position;
    logic signed [31:0] read_value;
    logic [6:0]         entry_total;
  } list_answer_t;

  logic clk = 1'b0;
  logic rst;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  sequential_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #4 clk = ~clk;

  // bench copy of the list
  logic signed [31:0] list_mem [sle_pkg::CAPACITY];
  int                 list_count;
  list_answer_t       answer_q [$];
  logic signed [31:0] value_pool [8];

  int send_idle_pct;
  int ready_stall_pct;
  int mismatch_count;
  int cycle_count;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // apply one request to the bench list and return the response it gives
  function automatic list_answer_t apply_request(logic [3:0] op, logic [6:0] pos,
                                                 logic signed [31:0] val);
    list_answer_t ans;
    int           slot;
    int           p;
    p                  = int'(pos);
    ans.status         = sle_pkg::ST_OK;
    ans.found_position = '0;
    ans.read_value     = '0;
    case (op)
      sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_INSERT: begin
        if (op == sle_pkg::OP_INSERT && (p == 0 || p > list_count + 1)) begin
          ans.status = sle_pkg::ST_BADPOS;
        end else if (list_count >= sle_pkg::CAPACITY) begin
          ans.status = sle_pkg::ST_FULL;
        end else begin
          slot = (op == sle_pkg::OP_PUSH_BACK)  ? list_count :
                 (op == sle_pkg::OP_PUSH_FRONT) ? 0 : p - 1;
          for (int i = list_count; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = val;
          list_count++;
        end
      end
      sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
        if (list_count == 0) begin
          ans.status = sle_pkg::ST_EMPTY;
        end else begin
          if (op == sle_pkg::OP_POP_FRONT)
            for (int i = 0; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      sle_pkg::OP_ERASE, sle_pkg::OP_MODIFY, sle_pkg::OP_READ: begin
        if (p == 0 || p > list_count) begin
          ans.status = sle_pkg::ST_BADPOS;
        end else if (op == sle_pkg::OP_ERASE) begin
          for (int i = p - 1; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end else if (op == sle_pkg::OP_MODIFY) begin
          list_mem[p-1] = val;
        end else begin
          ans.read_value = list_mem[p-1];
        end
      end
      sle_pkg::OP_FIND: begin
        ans.status = sle_pkg::ST_NOTFOUND;
        for (int i = 0; i < list_count; i++) begin
          if (list_mem[i] == val) begin
            ans.status         = sle_pkg::ST_OK;
            ans.found_position = 7'(i + 1);
            break;
          end
        end
      end
      default: ;
    endcase
    ans.entry_total = 7'(list_count);
    return ans;
  endfunction

  // response side: random back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // compare each response beat with the oldest expectation
  always @(posedge clk) begin : check_answers
    list_answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing outstanding (st=%0d tot=%0d)",
                                  rsp_ch.status, rsp_ch.entry_total));
      end else begin
        want = answer_q.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.found_position !== want.found_position
            || rsp_ch.read_value !== want.read_value
            || rsp_ch.entry_total !== want.entry_total)
          report_mismatch($sformatf({"got st=%0d fp=%0d rv=%h tot=%0d, ",
                                     "want st=%0d fp=%0d rv=%h tot=%0d"},
                                    rsp_ch.status, rsp_ch.found_position,
                                    rsp_ch.read_value, rsp_ch.entry_total,
                                    want.status, want.found_position,
                                    want.read_value, want.entry_total));
      end
    end
  end

  // send one request beat; the expectation is recorded on acceptance
  task automatic send_request(logic [3:0] op, logic [6:0] pos, logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.position  <= pos;
    req_ch.value     <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    answer_q.push_back(apply_request(op, pos, val));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 40) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // mix of adds, removals, accesses and spare codes; grow_pct steers the list length
  function automatic logic [3:0] pick_operation(int grow_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) return 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    if (r < 62) begin
      if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0:       return sle_pkg::OP_PUSH_BACK;
          1:       return sle_pkg::OP_PUSH_FRONT;
          default: return sle_pkg::OP_INSERT;
        endcase
      end
      case ($urandom_range(2))
        0:       return sle_pkg::OP_POP_BACK;
        1:       return sle_pkg::OP_POP_FRONT;
        default: return sle_pkg::OP_ERASE;
      endcase
    end
    case ($urandom_range(2))
      0:       return sle_pkg::OP_FIND;
      1:       return sle_pkg::OP_MODIFY;
      default: return sle_pkg::OP_READ;
    endcase
  endfunction

  // mostly valid positions, with zero, just-past-end and wild ones mixed in
  function automatic logic [6:0] pick_position(logic [3:0] op);
    int top;
    int r;
    top = (op == sle_pkg::OP_INSERT) ? list_count + 1 : list_count;
    r   = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return 7'($urandom_range(127));
    if (r < 18) return 7'(top + 1);
    if (top == 0) return 7'($urandom_range(2));
    if (r < 26) return 7'(top);
    return 7'($urandom_range(top, 1));
  endfunction

  // every removal and access against an empty list
  task automatic test_empty_list();
    send_request(sle_pkg::OP_POP_BACK, 7'd0, 32'sd0);
    send_request(sle_pkg::OP_POP_FRONT, 7'd0, 32'sd0);
    send_request(sle_pkg::OP_ERASE, 7'd1, 32'sd0);
    send_request(sle_pkg::OP_MODIFY, 7'd1, 32'sd5);
    send_request(sle_pkg::OP_READ, 7'd1, 32'sd0);
    send_request(sle_pkg::OP_READ, 7'd0, 32'sd0);
    send_request(sle_pkg::OP_FIND, 7'd0, 32'sd0);
  endtask

  // edits at both ends and in the middle, extreme values, bad positions, spare codes
  task automatic test_edits_and_extremes();
    send_request(sle_pkg::OP_PUSH_BACK, 7'd0, 32'sh8000_0000);
    send_request(sle_pkg::OP_PUSH_BACK, POS_TOP, 32'sh7FFF_FFFF);
    send_request(sle_pkg::OP_PUSH_FRONT, 7'd0, -32'sd1);
    send_request(sle_pkg::OP_INSERT, 7'd2, 32'sd0);
    send_request(sle_pkg::OP_INSERT, 7'd5, 32'sh7FFF_FFFF);
    send_request(sle_pkg::OP_INSERT, 7'd0, 32'sd1);
    send_request(sle_pkg::OP_INSERT, 7'd7, 32'sd1);
    send_request(sle_pkg::OP_READ, 7'd1, 32'sd0);
    send_request(sle_pkg::OP_READ, 7'd5, 32'sd0);
    send_request(sle_pkg::OP_READ, 7'd6, 32'sd0);
    send_request(sle_pkg::OP_READ, POS_TOP, 32'sd0);
    send_request(sle_pkg::OP_FIND, 7'd0, 32'sh8000_0000);
    send_request(sle_pkg::OP_FIND, 7'd0, 32'sh7FFF_FFFF);
    send_request(sle_pkg::OP_FIND, 7'd0, 32'sd12345);
    send_request(sle_pkg::OP_MODIFY, 7'd3, 32'sh5A5A_A5A5);
    send_request(sle_pkg::OP_MODIFY, 7'd6, 32'sd1);
    send_request(sle_pkg::OP_ERASE, 7'd2, 32'sd0);
    send_request(sle_pkg::OP_ERASE, 7'd0, 32'sd0);
    send_request(sle_pkg::OP_ERASE, POS_TOP, 32'sd0);
    send_request(OP_SPARE_FIRST, 7'd1, 32'sd1);
    send_request(OP_SPARE_LAST, POS_TOP, -32'sd1);
  endtask

  // fill to capacity, then every add and the longest walks
  task automatic test_full_list();
    while (list_count < sle_pkg::CAPACITY)
      send_request(sle_pkg::OP_PUSH_BACK, 7'd0, $urandom);
    send_request(sle_pkg::OP_PUSH_BACK, 7'd0, 32'sd1);
    send_request(sle_pkg::OP_PUSH_FRONT, 7'd0, 32'sd1);
    send_request(sle_pkg::OP_INSERT, 7'(sle_pkg::CAPACITY + 1), 32'sd1);
    send_request(sle_pkg::OP_INSERT, 7'(sle_pkg::CAPACITY + 2), 32'sd1);
    send_request(sle_pkg::OP_READ, 7'(sle_pkg::CAPACITY), 32'sd0);
    send_request(sle_pkg::OP_FIND, 7'd0, list_mem[sle_pkg::CAPACITY-1]);
    send_request(sle_pkg::OP_ERASE, 7'd1, 32'sd0);
    send_request(sle_pkg::OP_INSERT, 7'd1, 32'sh8000_0000);
    send_request(sle_pkg::OP_POP_FRONT, 7'd0, 32'sd0);
  endtask

  // random traffic that sweeps the length between empty and full
  task automatic test_random_traffic(int items, int send_pct, int stall_pct);
    logic [3:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] val;
    bit                 grow;
    send_idle_pct   = send_pct;
    ready_stall_pct = stall_pct;
    grow            = (list_count < sle_pkg::CAPACITY / 2);
    for (int n = 0; n < items; n++) begin
      // turn round after lingering a little at either end
      if (list_count == sle_pkg::CAPACITY && $urandom_range(99) < 15) grow = 1'b0;
      if (list_count == 0 && $urandom_range(99) < 15) grow = 1'b1;
      op  = pick_operation(grow ? 80 : 20);
      pos = pick_position(op);
      if (op == sle_pkg::OP_FIND && list_count != 0 && $urandom_range(1) == 1)
        val = list_mem[$urandom_range(list_count - 1)];
      else
        val = pick_value();
      send_request(op, pos, val);
    end
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = '0;
    req_ch.position  = '0;
    req_ch.value     = '0;
    list_count       = 0;
    mismatch_count   = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    ready_stall_pct  = 0;
    value_pool[0]    = 32'sh8000_0000;
    value_pool[1]    = 32'sh7FFF_FFFF;
    value_pool[2]    = 32'sd0;
    value_pool[3]    = -32'sd1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_edits_and_extremes();
    test_full_list();
    test_random_traffic(340, 0, 0);
    test_random_traffic(340, 47, 0);
    test_random_traffic(340, 0, 47);
    test_random_traffic(335, 37, 37);

    // let outstanding responses drain, then watch for stray beats
    req_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
